// ===== design/ptil_pkg.sv =====
// ----------------------------------------------------------------------------
// ptil_pkg
// Shared constants, action codes and controller/datapath bundles for the
// prefix tree insert/lookup block.
// ----------------------------------------------------------------------------
package ptil_pkg;

  localparam int NODE_COUNT_DEF    = 1024;
  localparam int ALPHABET_SIZE_DEF = 26;

  localparam int ACTION_W = 2;
  localparam int LETTER_W = 5;

  localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_SEARCH = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_PREFIX = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic clear_en;
    logic take_item;
    logic walk;
    logic mark_read;
    logic result_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clear_done;
    logic walk_needed;
    logic item_last;
    logic held_last;
    logic out_free;
  } sts_t;

endpackage

// ===== design/ptil_if.sv =====
// ----------------------------------------------------------------------------
// ptil_if
// Valid/ready channels of the prefix tree block: letter items in, results out.
// ----------------------------------------------------------------------------
interface ptil_in_if;
  logic                           valid;
  logic                           ready;
  logic [ptil_pkg::ACTION_W-1:0]  action;
  logic [ptil_pkg::LETTER_W-1:0]  letter;
  logic                           has_letter;
  logic                           last_letter;

  modport source (output valid, action, letter, has_letter, last_letter, input ready);
  modport sink   (input valid, action, letter, has_letter, last_letter, output ready);
endinterface

interface ptil_out_if;
  logic valid;
  logic ready;
  logic hit;
  logic status;

  modport source (output valid, hit, status, input ready);
  modport sink   (input valid, hit, status, output ready);
endinterface

// ===== design/ptil_ram.sv =====
// ----------------------------------------------------------------------------
// ptil_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module ptil_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/ptil_ctrl.sv =====
// ----------------------------------------------------------------------------
// ptil_ctrl
// Sequencer: clearing sweep after reset, then per-item walk and result steps.
// ----------------------------------------------------------------------------
module ptil_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_ready,
  input  ptil_pkg::sts_t sts,
  output ptil_pkg::cmd_t cmd
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_WALK   = 3'd2;
  localparam logic [2:0] ST_FINISH = 3'd3;
  localparam logic [2:0] ST_RESULT = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    item_ready = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (sts.clear_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.take_item = 1'b1;
          if (sts.walk_needed) begin
            state_next = ST_WALK;
          end else if (sts.item_last) begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_WALK: begin
        cmd.walk   = 1'b1;
        state_next = sts.held_last ? ST_FINISH : ST_IDLE;
      end
      ST_FINISH: begin
        // fetch the word-end mark of the final node
        cmd.mark_read = 1'b1;
        state_next    = ST_RESULT;
      end
      ST_RESULT: begin
        if (sts.out_free) begin
          cmd.result_load = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/ptil_dp.sv =====
// ----------------------------------------------------------------------------
// ptil_dp
// Datapath: child-table row memory, word-end memory, cursor, allocation
// counter, clearing address and result register.
// ----------------------------------------------------------------------------
module ptil_dp #(
  parameter int NODE_COUNT    = ptil_pkg::NODE_COUNT_DEF,
  parameter int ALPHABET_SIZE = ptil_pkg::ALPHABET_SIZE_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ptil_pkg::cmd_t                cmd,
  output ptil_pkg::sts_t                sts,
  input  logic [ptil_pkg::ACTION_W-1:0] action,
  input  logic [ptil_pkg::LETTER_W-1:0] letter,
  input  logic                          has_letter,
  input  logic                          last_letter,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          hit,
  output logic                          status
);

  localparam int NODE_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int SEL_W  = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
  localparam int ROW_W  = ALPHABET_SIZE * NODE_W;

  typedef logic [ALPHABET_SIZE-1:0][NODE_W-1:0] row_t;

  // item registers
  logic [ptil_pkg::ACTION_W-1:0] action_q;
  logic [ptil_pkg::LETTER_W-1:0] letter_q;
  logic                          last_q;

  // walk state
  logic [NODE_W-1:0] cursor;
  logic [NODE_W:0]   nodes_used;
  logic              path_missing;
  logic              pool_full_seen;
  logic [NODE_W-1:0] clr_addr;

  row_t              row_q;
  row_t              row_wr;
  logic              mark_q;
  logic [SEL_W-1:0]  sel;
  logic [NODE_W-1:0] child;
  logic              in_range;
  logic              pool_empty;
  logic              alloc;
  logic              mark_set;
  logic              hit_next;
  logic              status_next;

  assign in_range   = {4'd0, letter} < 9'(ALPHABET_SIZE);
  assign sel        = SEL_W'(letter_q);
  assign child      = row_q[sel];
  assign pool_empty = nodes_used >= (NODE_W + 1)'(NODE_COUNT);
  assign alloc      = cmd.walk && (child == '0) && (action_q == ptil_pkg::ACT_INSERT)
                      && !pool_empty;

  always_comb begin
    row_wr      = row_q;
    row_wr[sel] = nodes_used[NODE_W-1:0];
  end

  assign sts.clear_done  = clr_addr == NODE_W'(NODE_COUNT - 1);
  assign sts.walk_needed = has_letter && !path_missing && in_range;
  assign sts.item_last   = last_letter;
  assign sts.held_last   = last_q;
  assign sts.out_free    = !out_valid || out_ready;

  ptil_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NODE_COUNT)
  ) u_child_ram (
    .clk     (clk),
    .wr_en   (cmd.clear_en || alloc),
    .wr_addr (cmd.clear_en ? clr_addr : cursor),
    .wr_data (cmd.clear_en ? row_t'('0) : row_wr),
    .rd_en   (cmd.take_item),
    .rd_addr (cursor),
    .rd_data (row_q)
  );

  ptil_ram #(
    .WIDTH (1),
    .DEPTH (NODE_COUNT)
  ) u_mark_ram (
    .clk     (clk),
    .wr_en   (cmd.clear_en || mark_set),
    .wr_addr (cmd.clear_en ? clr_addr : cursor),
    .wr_data (!cmd.clear_en),
    .rd_en   (cmd.mark_read),
    .rd_addr (cursor),
    .rd_data (mark_q)
  );

  always_comb begin
    status_next = 1'b0;
    mark_set    = 1'b0;
    case (action_q)
      ptil_pkg::ACT_INSERT: begin
        hit_next    = !pool_full_seen && !path_missing;
        status_next = pool_full_seen;
        mark_set    = cmd.result_load && !pool_full_seen && !path_missing;
      end
      ptil_pkg::ACT_SEARCH: begin
        hit_next = !path_missing && mark_q;
      end
      ptil_pkg::ACT_PREFIX: begin
        hit_next = !path_missing;
      end
      default: begin
        hit_next = !path_missing;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      action_q <= action;
      letter_q <= letter;
      last_q   <= last_letter;
    end
    if (cmd.result_load) begin
      hit    <= hit_next;
      status <= status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr       <= '0;
      cursor         <= '0;
      nodes_used     <= (NODE_W + 1)'(1);
      path_missing   <= 1'b0;
      pool_full_seen <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cmd.clear_en) begin
        clr_addr <= clr_addr + 1'b1;
      end
      // a letter beyond the alphabet breaks the path
      if (cmd.take_item && has_letter && !path_missing && !in_range) begin
        path_missing <= 1'b1;
      end
      if (cmd.walk) begin
        if (child != '0) begin
          cursor <= child;
        end else if (alloc) begin
          cursor     <= nodes_used[NODE_W-1:0];
          nodes_used <= nodes_used + 1'b1;
        end else begin
          path_missing <= 1'b1;
          if (action_q == ptil_pkg::ACT_INSERT) begin
            pool_full_seen <= 1'b1;
          end
        end
      end
      if (cmd.result_load) begin
        cursor         <= '0;
        path_missing   <= 1'b0;
        pool_full_seen <= 1'b0;
        out_valid      <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== design/prefix_tree_insert_lookup.sv =====
// ----------------------------------------------------------------------------
// prefix_tree_insert_lookup
// Letter-serial prefix tree over a fixed node pool: insert, exact search and
// prefix test, one result per word.
// ----------------------------------------------------------------------------
//   channel  | dir | payload                                  | transaction
//   ---------+-----+------------------------------------------+-----------------
//   item     | in  | action, letter, has_letter, last_letter  | valid && ready
//   result   | out | hit, status                              | valid && ready
//
// A letter item takes one child-row read in IDLE, then the compare and
// optional write-back that moves the cursor in WALK; an item with no walk
// is taken in IDLE alone. A last item adds the word-end mark read, then the
// result. After reset a clearing sweep writes all NODE_COUNT rows (one row
// per cycle) while item.ready stays low.
// A waiting result stalls the next word's result step, item.ready low meanwhile.
// ----------------------------------------------------------------------------
module prefix_tree_insert_lookup #(
  parameter int NODE_COUNT    = ptil_pkg::NODE_COUNT_DEF,
  parameter int ALPHABET_SIZE = ptil_pkg::ALPHABET_SIZE_DEF
) (
  input logic              clk,
  input logic              rst,
  ptil_in_if.sink          item,
  ptil_out_if.source       result
);

  ptil_pkg::cmd_t cmd;
  ptil_pkg::sts_t sts;

  ptil_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  ptil_dp #(
    .NODE_COUNT    (NODE_COUNT),
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .action      (item.action),
    .letter      (item.letter),
    .has_letter  (item.has_letter),
    .last_letter (item.last_letter),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .hit         (result.hit),
    .status      (result.status)
  );

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.result_load |-> sts.out_free)
    else $error("result loaded over a pending transaction");

  a_no_take_in_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.clear_en |-> !item.ready)
    else $error("item accepted during clearing sweep");

  a_single_walk: assert property (@(posedge clk) disable iff (rst)
    cmd.walk |=> !cmd.walk)
    else $error("walk step repeated");

  a_full_means_miss: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !(result.hit && result.status))
    else $error("pool-full result reports a hit");
`endif

endmodule

// ===== tb/trie_answer_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trie_answer_check
// Watches the item and result channels of the prefix tree block. It keeps its
// own copy of the node pool, walks every accepted letter through it, and
// queues the answer that each last item should produce. Each accepted result
// is compared field by field with the oldest queued answer.
// ----------------------------------------------------------------------------
module trie_answer_check
  import ptil_pkg::*;
#(
  parameter int NODES = NODE_COUNT_DEF,
  parameter int ALPHA = ALPHABET_SIZE_DEF
) (
  input  logic clk,
  input  logic rst,
  ptil_in_if   item,
  ptil_out_if  result,
  output int   bad_answers,
  output int   answers_owed
);

  localparam int NODE_W = $clog2(NODES);

  typedef struct packed {
    logic hit;
    logic status;
  } answer_t;

  logic [NODE_W-1:0] child_of [NODES*ALPHA];
  bit                ends_word [NODES];
  int unsigned       next_free;
  logic [NODE_W-1:0] cursor;
  bit                off_path;
  bit                pool_ran_out;
  answer_t           answer_q [$];

  task automatic clear_trie();
    for (int i = 0; i < NODES*ALPHA; i++) child_of[i] = '0;
    for (int i = 0; i < NODES; i++) ends_word[i] = 1'b0;
    next_free    = 1;
    cursor       = '0;
    off_path     = 1'b0;
    pool_ran_out = 1'b0;
  endtask

  // Move the cursor one letter down; insert grows the path while nodes last.
  task automatic walk_trie_letter(input logic [ACTION_W-1:0] act,
                                  input logic [LETTER_W-1:0] code);
    int unsigned       slot;
    logic [NODE_W-1:0] nxt;
    if (off_path) return;
    if (code >= ALPHA) begin
      off_path = 1'b1;
      return;
    end
    slot = cursor * ALPHA + code;
    nxt  = child_of[slot];
    if (nxt == '0) begin
      if (act != ACT_INSERT) begin
        off_path = 1'b1;
        return;
      end
      if (next_free >= NODES) begin
        off_path     = 1'b1;
        pool_ran_out = 1'b1;
        return;
      end
      nxt            = next_free[NODE_W-1:0];
      next_free      = next_free + 1;
      child_of[slot] = nxt;
    end
    cursor = nxt;
  endtask

  task automatic take_item(input logic [ACTION_W-1:0] act,
                           input logic [LETTER_W-1:0] code,
                           input logic has, input logic fin);
    answer_t ans;
    if (has) walk_trie_letter(act, code);
    if (fin) begin
      ans.status = 1'b0;
      if (act == ACT_INSERT) begin
        if (pool_ran_out) begin
          ans.hit    = 1'b0;
          ans.status = 1'b1;
        end else if (off_path) begin
          ans.hit = 1'b0;
        end else begin
          ends_word[cursor] = 1'b1;
          ans.hit           = 1'b1;
        end
      end else if (act == ACT_SEARCH) begin
        ans.hit = !off_path && ends_word[cursor];
      end else begin
        // prefix test, and the unused code behaves the same
        ans.hit = !off_path;
      end
      answer_q.push_back(ans);
      cursor       = '0;
      off_path     = 1'b0;
      pool_ran_out = 1'b0;
    end
  endtask

  task automatic check_answer();
    answer_t want;
    bit      wrong;
    if (answer_q.size() == 0) begin
      $display("%0t: result with none expected: hit=%0b status=%0b",
               $time, result.hit, result.status);
      bad_answers <= bad_answers + 1;
      return;
    end
    want  = answer_q.pop_front();
    wrong = 1'b0;
    if (result.hit !== want.hit) begin
      $display("%0t: hit mismatch: expected %0b, got %0b", $time, want.hit, result.hit);
      wrong = 1'b1;
    end
    if (result.status !== want.status) begin
      $display("%0t: status mismatch: expected %0b, got %0b",
               $time, want.status, result.status);
      wrong = 1'b1;
    end
    if (wrong) bad_answers <= bad_answers + 1;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_trie();
      answer_q.delete();
      answers_owed <= 0;
    end else begin
      // retire the older answer before queuing a new one
      if (result.valid && result.ready) check_answer();
      if (item.valid && item.ready)
        take_item(item.action, item.letter, item.has_letter, item.last_letter);
      answers_owed <= answer_q.size();
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives words into the prefix tree block: a short directed run over the
// corner cases, then random words that first fill the node pool with long
// inserts and then mix queries, re-inserts past a full pool, bad letters,
// empty words and mixed-action words. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_top;
  import ptil_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_UNDEF = 2'd3;

  localparam int MAX_LEN      = 32;
  localparam int BANK_DEPTH   = 128;
  localparam int TOTAL_ITEMS  = 1550;
  localparam int FILL_LETTERS = 1200;
  localparam int IDLE_LIMIT   = 4096;
  localparam int TAIL_CYCLES  = 16;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ptil_in_if  item_ch ();
  ptil_out_if result_ch ();

  int bad_answers;
  int answers_owed;

  prefix_tree_insert_lookup dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  trie_answer_check chk (
    .clk          (clk),
    .rst          (rst),
    .item         (item_ch),
    .result       (result_ch),
    .bad_answers  (bad_answers),
    .answers_owed (answers_owed)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  logic [LETTER_W-1:0] word_buf [MAX_LEN];
  int                  word_len;
  logic [LETTER_W-1:0] bank [BANK_DEPTH][MAX_LEN];
  int                  bank_len [BANK_DEPTH];
  int                  bank_cnt;
  bit                  no_idle;
  int                  items_sent;
  int                  insert_letters;

  function automatic logic [LETTER_W-1:0] any_letter();
    return LETTER_W'($urandom_range(0, ALPHABET_SIZE_DEF - 1));
  endfunction

  function automatic logic [ACTION_W-1:0] random_action();
    case ($urandom_range(0, 3))
      0:       return ACT_INSERT;
      1:       return ACT_SEARCH;
      2:       return ACT_PREFIX;
      default: return ACT_UNDEF;
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_item(input logic [ACTION_W-1:0] act, input logic [LETTER_W-1:0] code,
                           input logic has, input logic fin);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_ch.valid       <= 1'b1;
    item_ch.action      <= act;
    item_ch.letter      <= code;
    item_ch.has_letter  <= has;
    item_ch.last_letter <= fin;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    @(negedge clk);
    if (has || fin) items_sent++;
  endtask

  task automatic send_word(input logic [ACTION_W-1:0] act, input bit mixed, input bit fillers);
    if (word_len == 0) begin
      send_item(act, LETTER_W'($urandom), 1'b0, 1'b1);
      return;
    end
    for (int i = 0; i < word_len; i++) begin
      // letterless, non-final items should leave the walk untouched
      if (fillers && $urandom_range(0, 9) == 0)
        send_item(random_action(), LETTER_W'($urandom), 1'b0, 1'b0);
      send_item(mixed ? random_action() : act, word_buf[i], 1'b1, i == word_len - 1);
    end
  endtask

  task automatic make_random(input int lo, input int hi);
    word_len = $urandom_range(lo, hi);
    for (int i = 0; i < word_len; i++) word_buf[i] = any_letter();
  endtask

  task automatic remember();
    int idx;
    if (word_len == 0) return;
    if (bank_cnt < BANK_DEPTH) begin
      idx = bank_cnt;
      bank_cnt++;
    end else begin
      idx = $urandom_range(0, BANK_DEPTH - 1);
    end
    bank_len[idx] = word_len;
    for (int i = 0; i < word_len; i++) bank[idx][i] = word_buf[i];
  endtask

  // Load a stored word, as is or truncated, extended or with one letter changed.
  task automatic pick_stored();
    int idx;
    int roll;
    int extra;
    if (bank_cnt == 0) begin
      make_random(1, 6);
      return;
    end
    idx      = $urandom_range(0, bank_cnt - 1);
    word_len = bank_len[idx];
    for (int i = 0; i < word_len; i++) word_buf[i] = bank[idx][i];
    roll = $urandom_range(0, 99);
    if (roll < 40) begin
      return;
    end else if (roll < 65) begin
      word_len = $urandom_range(0, word_len);
    end else if (roll < 85) begin
      extra = $urandom_range(1, 3);
      for (int i = 0; i < extra; i++) begin
        if (word_len < MAX_LEN) begin
          word_buf[word_len] = any_letter();
          word_len++;
        end
      end
    end else begin
      word_buf[$urandom_range(0, word_len - 1)] = any_letter();
    end
  endtask

  initial begin : result_sink
    int stall;
    int run;
    run = 0;
    forever begin
      if (run > 0) begin
        stall = 0;
        run--;
      end else begin
        stall = $urandom_range(0, 10);
        if ($urandom_range(0, 7) == 0) run = $urandom_range(5, 20);
      end
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_ch.ready <= 1'b1;
      @(posedge clk);
      while (!result_ch.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    int roll;
    item_ch.valid       = 1'b0;
    item_ch.action      = ACT_INSERT;
    item_ch.letter      = '0;
    item_ch.has_letter  = 1'b0;
    item_ch.last_letter = 1'b0;
    bank_cnt            = 0;
    items_sent          = 0;
    insert_letters      = 0;
    no_idle             = 1'b0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty word: root is not a word end until an empty insert marks it
    send_item(ACT_SEARCH, '0, 1'b0, 1'b1);
    send_item(ACT_INSERT, '1, 1'b0, 1'b1);
    send_item(ACT_SEARCH, '0, 1'b0, 1'b1);

    // first and last letters of the alphabet
    word_buf[0] = '0;
    word_buf[1] = LETTER_W'(ALPHABET_SIZE_DEF - 1);
    word_len    = 2;
    send_word(ACT_INSERT, 1'b0, 1'b0);
    remember();
    send_word(ACT_SEARCH, 1'b0, 1'b0);
    send_word(ACT_UNDEF, 1'b0, 1'b0);
    word_len = 1;
    send_word(ACT_PREFIX, 1'b0, 1'b0);
    send_word(ACT_SEARCH, 1'b0, 1'b0);

    // letter codes past the alphabet break the path
    send_item(ACT_INSERT, '1, 1'b1, 1'b1);
    send_item(ACT_SEARCH, LETTER_W'(ALPHABET_SIZE_DEF), 1'b1, 1'b1);
    send_item(ACT_PREFIX, LETTER_W'(ALPHABET_SIZE_DEF - 1), 1'b1, 1'b0);
    send_item(ACT_PREFIX, LETTER_W'(30), 1'b1, 1'b1);

    // letterless items inside a word hold the cursor
    send_item(ACT_INSERT, 5'd3, 1'b1, 1'b0);
    send_item(ACT_INSERT, '1, 1'b0, 1'b0);
    send_item(ACT_INSERT, 5'd4, 1'b1, 1'b1);
    send_item(ACT_SEARCH, 5'd3, 1'b1, 1'b0);
    send_item(ACT_SEARCH, 5'd4, 1'b1, 1'b0);
    send_item(ACT_SEARCH, '0, 1'b0, 1'b1);

    // each item walks with its own action
    send_item(ACT_INSERT, 5'd7, 1'b1, 1'b0);
    send_item(ACT_SEARCH, 5'd3, 1'b1, 1'b0);
    send_item(ACT_PREFIX, 5'd4, 1'b1, 1'b1);

    while (items_sent < TOTAL_ITEMS) begin
      no_idle = ($urandom_range(0, 3) == 0);
      roll    = $urandom_range(0, 99);
      if (insert_letters < FILL_LETTERS) begin
        // long fresh inserts drain the node pool
        if (roll < 90) begin
          make_random(14, 24);
          remember();
          insert_letters += word_len;
          send_word(ACT_INSERT, 1'b0, 1'b1);
        end else begin
          pick_stored();
          send_word((roll < 96) ? ACT_SEARCH : ACT_PREFIX, 1'b0, 1'b1);
        end
      end else if (roll < 15) begin
        make_random(1, 8);
        remember();
        send_word(ACT_INSERT, 1'b0, 1'b1);
      end else if (roll < 30) begin
        pick_stored();
        send_word(ACT_INSERT, 1'b0, 1'b1);
      end else if (roll < 55) begin
        pick_stored();
        send_word(ACT_SEARCH, 1'b0, 1'b1);
      end else if (roll < 72) begin
        pick_stored();
        send_word(($urandom_range(0, 3) == 0) ? ACT_UNDEF : ACT_PREFIX, 1'b0, 1'b1);
      end else if (roll < 82) begin
        make_random(1, 8);
        send_word(random_action(), 1'b0, 1'b1);
      end else if (roll < 90) begin
        pick_stored();
        send_word(random_action(), 1'b1, 1'b1);
      end else if (roll < 96) begin
        pick_stored();
        if (word_len == 0) word_len = 1;
        word_buf[$urandom_range(0, word_len - 1)] =
          LETTER_W'($urandom_range(ALPHABET_SIZE_DEF, (1 << LETTER_W) - 1));
        send_word(random_action(), 1'b0, 1'b1);
      end else begin
        word_len = 0;
        send_word(random_action(), 1'b0, 1'b0);
      end
    end

    item_ch.valid <= 1'b0;
    while (answers_owed != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (bad_answers == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// ===== sim.f =====
design/ptil_pkg.sv
design/ptil_if.sv
design/ptil_ram.sv
design/ptil_ctrl.sv
design/ptil_dp.sv
design/prefix_tree_insert_lookup.sv
tb/trie_answer_check.sv
tb/tb_top.sv
